### rtl/core/base91_stream_encoder_macros.svh
// ----------------------------------------------------------------------------
// base91_stream_encoder_macros.svh
// Assertion macros used by the basE91 encoder RTL.
// ----------------------------------------------------------------------------
`ifndef BASE91_STREAM_ENCODER_MACROS_SVH
`define BASE91_STREAM_ENCODER_MACROS_SVH

`ifndef NO_ASSERTIONS

// Same-cycle implication, disabled in reset
`define B91_ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled in reset
`define B91_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define B91_ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg)
`define B91_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)

`endif

`endif

### rtl/core/b91_pkg.sv
// ----------------------------------------------------------------------------
// b91_pkg
// Types, constants and the character table of the basE91 encoder.
// ----------------------------------------------------------------------------
package b91_pkg;

    localparam logic ACTION_DATA  = 1'b0;
    localparam logic ACTION_FLUSH = 1'b1;

    localparam int QUEUE_W = 21;
    localparam int COUNT_W = 5;
    localparam int VAL_W   = 14;
    localparam int CHAR_W  = 7;
    localparam int IDX_W   = 7;
    localparam int RADIX   = 91;

    localparam logic [COUNT_W-1:0] SHORT_BITS = 5'd13;
    localparam logic [COUNT_W-1:0] LONG_BITS  = 5'd14;
    localparam logic [COUNT_W-1:0] BYTE_BITS  = 5'd8;
    localparam logic [COUNT_W-1:0] TAIL_BITS  = 5'd7;
    localparam logic [12:0]        SHORT_MIN  = 13'd88;  // values at or below take 14 bits
    localparam logic [12:0]        TAIL_MAX   = 13'd90;

    // pair of alphabet characters for one value: low digit first
    typedef struct packed {
        logic [CHAR_W-1:0] lo;
        logic [CHAR_W-1:0] hi;
    } b91_pair_t;

    localparam logic [CHAR_W-1:0] ALPHABET [0:RADIX-1] = '{
        7'd65, 7'd66, 7'd67, 7'd68, 7'd69, 7'd70, 7'd71, 7'd72, 7'd73, 7'd74,
        7'd75, 7'd76, 7'd77, 7'd78, 7'd79, 7'd80, 7'd81, 7'd82, 7'd83, 7'd84,
        7'd85, 7'd86, 7'd87, 7'd88, 7'd89, 7'd90,
        7'd97, 7'd98, 7'd99, 7'd100, 7'd101, 7'd102, 7'd103, 7'd104, 7'd105,
        7'd106, 7'd107, 7'd108, 7'd109, 7'd110, 7'd111, 7'd112, 7'd113, 7'd114,
        7'd115, 7'd116, 7'd117, 7'd118, 7'd119, 7'd120, 7'd121, 7'd122,
        7'd48, 7'd49, 7'd50, 7'd51, 7'd52, 7'd53, 7'd54, 7'd55, 7'd56, 7'd57,
        7'd33, 7'd35, 7'd36, 7'd37, 7'd38, 7'd40, 7'd41, 7'd42, 7'd43, 7'd44,
        7'd46, 7'd47, 7'd58, 7'd59, 7'd60, 7'd61, 7'd62, 7'd63, 7'd64, 7'd91,
        7'd93, 7'd94, 7'd95, 7'd96, 7'd123, 7'd124, 7'd125, 7'd126, 7'd34
    };

    function automatic logic [CHAR_W-1:0] b91_char(input logic [IDX_W-1:0] idx);
        b91_char = ALPHABET[idx];
    endfunction

endpackage

### rtl/core/b91_symbol.sv
// ----------------------------------------------------------------------------
// b91_symbol
// Splits a 14-bit value into its two radix-91 digits and maps them to
// alphabet characters. Division uses a reciprocal multiply, exact for any
// 14-bit value.
// ----------------------------------------------------------------------------
module b91_symbol (
    input  logic [13:0]          val,
    output b91_pkg::b91_pair_t   pair
);
    import b91_pkg::*;

    localparam int          RECIP_SHIFT = 20;
    localparam logic [14:0] RECIP       = 15'd11523;  // ceil(2^20 / 91)

    logic [28:0]      prod;
    logic [7:0]       quot;
    logic [14:0]      quot_x91;
    logic [IDX_W-1:0] rem;
    logic [IDX_W-1:0] quot_mod;

    always_comb begin
        prod     = {15'd0, val} * {14'd0, RECIP};
        quot     = prod[RECIP_SHIFT +: 8];
        quot_x91 = {7'd0, quot} * 15'(RADIX);
        rem      = IDX_W'({1'b0, val} - quot_x91);
        // high digit wraps once for out-of-range queues
        if (quot >= 8'(RADIX)) begin
            quot_mod = IDX_W'(quot - 8'(RADIX));
        end else begin
            quot_mod = quot[IDX_W-1:0];
        end
        pair.lo = b91_char(rem);
        pair.hi = b91_char(quot_mod);
    end

endmodule

### rtl/core/base91_stream_encoder.sv
// ----------------------------------------------------------------------------
// base91_stream_encoder
// Streaming basE91 text encoder with bit queue, value register and a
// two-character output register.
// ----------------------------------------------------------------------------
// A request is taken whenever the value register is free or moves on in that
// cycle, so a byte that yields no character never occupies the value register
// and the block keeps pace with the result side. A byte or flush that yields
// two characters occupies the result channel, one character per cycle while
// m_tready is high, for both characters, which limits how fast two-character
// requests can follow. The first character passes the value register and then
// the output register before it is presented on m_tdata. m_tlast marks the
// final character of each request's run; m_tuser marks the final character
// of a flush. A flush with an empty queue produces nothing.
module base91_stream_encoder (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // [7:0] data_byte
    input  logic [0:0] s_tuser,   // [0] action
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,   // [6:0] out_char, [7] zero
    output logic       m_tlast,
    output logic [0:0] m_tuser    // [0] message_end
);
    import b91_pkg::*;

    `include "base91_stream_encoder_macros.svh"

    logic [QUEUE_W-1:0] bit_queue_reg, bit_queue_next;
    logic [COUNT_W-1:0] bit_count_reg, bit_count_next;

    logic               a_valid_reg, a_valid_next;
    logic [VAL_W-1:0]   a_val_reg, a_val_next;
    logic               a_two_reg, a_two_next;
    logic               a_end_reg, a_end_next;

    logic [1:0]         pend_reg, pend_next;
    logic [CHAR_W-1:0]  ch0_reg, ch0_next;
    logic [CHAR_W-1:0]  ch1_reg, ch1_next;
    logic               end_reg, end_next;

    logic               s_accept;
    logic               b_free;
    logic               a_move;

    logic [COUNT_W-1:0] cnt_eff;
    logic [COUNT_W-1:0] cnt_add;
    logic [QUEUE_W-1:0] q_masked;
    logic [QUEUE_W-1:0] q_join;
    logic               emit_valid;
    logic               emit_two;
    logic               emit_end;
    logic [VAL_W-1:0]   emit_val;

    b91_pair_t          pair;

    b91_symbol u_symbol (
        .val  (a_val_reg),
        .pair (pair)
    );

    assign b_free   = (pend_reg == 2'd0) || ((pend_reg == 2'd1) && m_tready);
    assign a_move   = a_valid_reg && b_free;
    assign s_tready = !a_valid_reg || a_move;
    assign s_accept = s_tvalid && s_tready;

    // queue update and value selection
    always_comb begin
        cnt_eff  = (bit_count_reg > SHORT_BITS) ? SHORT_BITS : bit_count_reg;
        q_masked = bit_queue_reg & ((QUEUE_W'(1) << cnt_eff) - QUEUE_W'(1));
        q_join   = q_masked | ({13'd0, s_tdata} << cnt_eff);
        cnt_add  = cnt_eff + BYTE_BITS;

        bit_queue_next = bit_queue_reg;
        bit_count_next = bit_count_reg;
        emit_valid     = 1'b0;
        emit_two       = 1'b0;
        emit_end       = 1'b0;
        emit_val       = '0;

        if (s_accept) begin
            if (s_tuser[0] == ACTION_DATA) begin
                bit_queue_next = q_join;
                bit_count_next = cnt_add;
                if (cnt_add > SHORT_BITS) begin
                    emit_valid = 1'b1;
                    emit_two   = 1'b1;
                    if (q_join[12:0] > SHORT_MIN) begin
                        emit_val       = {1'b0, q_join[12:0]};
                        bit_queue_next = q_join >> SHORT_BITS;
                        bit_count_next = cnt_add - SHORT_BITS;
                    end else begin
                        emit_val       = q_join[VAL_W-1:0];
                        bit_queue_next = q_join >> LONG_BITS;
                        bit_count_next = cnt_add - LONG_BITS;
                    end
                end
            end else begin
                bit_queue_next = '0;
                bit_count_next = '0;
                if (cnt_eff != '0) begin
                    emit_valid = 1'b1;
                    emit_end   = 1'b1;
                    emit_val   = {1'b0, q_masked[12:0]};
                    emit_two   = (cnt_eff > TAIL_BITS) || (q_masked[12:0] > TAIL_MAX);
                end
            end
        end
    end

    // value register
    always_comb begin
        a_valid_next = a_valid_reg;
        a_val_next   = a_val_reg;
        a_two_next   = a_two_reg;
        a_end_next   = a_end_reg;
        if (a_move) begin
            a_valid_next = 1'b0;
        end
        if (s_accept && emit_valid) begin
            a_valid_next = 1'b1;
            a_val_next   = emit_val;
            a_two_next   = emit_two;
            a_end_next   = emit_end;
        end
    end

    // output register: ch0 is on the bus, ch1 waits behind it
    always_comb begin
        pend_next = pend_reg;
        ch0_next  = ch0_reg;
        ch1_next  = ch1_reg;
        end_next  = end_reg;
        if (a_move) begin
            pend_next = a_two_reg ? 2'd2 : 2'd1;
            ch0_next  = pair.lo;
            ch1_next  = pair.hi;
            end_next  = a_end_reg;
        end else if (m_tvalid && m_tready) begin
            pend_next = pend_reg - 2'd1;
            ch0_next  = ch1_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bit_queue_reg <= '0;
            bit_count_reg <= '0;
            a_valid_reg   <= 1'b0;
            pend_reg      <= 2'd0;
        end else begin
            bit_queue_reg <= bit_queue_next;
            bit_count_reg <= bit_count_next;
            a_valid_reg   <= a_valid_next;
            pend_reg      <= pend_next;
        end
    end

    always_ff @(posedge aclk) begin
        a_val_reg <= a_val_next;
        a_two_reg <= a_two_next;
        a_end_reg <= a_end_next;
        ch0_reg   <= ch0_next;
        ch1_reg   <= ch1_next;
        end_reg   <= end_next;
    end

    assign m_tvalid   = (pend_reg != 2'd0);
    assign m_tdata    = {1'b0, ch0_reg};
    assign m_tlast    = (pend_reg == 2'd1);
    assign m_tuser[0] = (pend_reg == 2'd1) && end_reg;

    `B91_ASSERT_IMPLIES(a_count_range, aclk, aresetn, 1'b1, bit_count_reg <= SHORT_BITS,
        "bit count exceeds 13")
    `B91_ASSERT_IMPLIES(a_queue_clean, aclk, aresetn, 1'b1,
        (bit_queue_reg >> bit_count_reg) == '0, "bits held above the count")
    `B91_ASSERT_NEXT(a_flush_clears, aclk, aresetn, s_accept && (s_tuser[0] == ACTION_FLUSH),
        (bit_count_reg == '0) && (bit_queue_reg == '0), "flush left bits in the queue")
    `B91_ASSERT_IMPLIES(a_end_is_last, aclk, aresetn, m_tvalid && m_tuser[0], m_tlast,
        "message end without last")
    `B91_ASSERT_NEXT(a_value_hold, aclk, aresetn, a_valid_reg && !a_move,
        a_valid_reg && $stable(a_val_reg), "pending value lost while output busy")

endmodule

### test/base91_stream_encoder_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// base91_stream_encoder_test
// Self-checking bench for the basE91 stream encoder. A short directed list
// covers flushes on an empty queue, all-zero and all-one bytes, the 88/89
// boundary between 14-bit and 13-bit takes, and flushes that end in one or two
// characters. A random byte stream with occasional flushes follows. Every
// accepted character is checked against a bit-queue model of the encoder,
// while both sides of the stream idle and stall at random.
// ----------------------------------------------------------------------------
module base91_stream_encoder_test;
    import b91_pkg::*;

    localparam int HALF_PERIOD   = 2;
    localparam int RESET_CYCLES  = 4;
    localparam int RANDOM_ITEMS  = 400;
    localparam int DRAIN_CYCLES  = 16;
    localparam int STALL_LIMIT   = 2000;
    localparam int REPORT_LIMIT  = 10;

    localparam int BASE          = 91;
    localparam int CHUNK_BITS    = 13;
    localparam int WIDE_BITS     = 14;
    localparam int OCTET_BITS    = 8;
    localparam int TAIL_LIMIT    = 7;
    localparam int NARROW_FLOOR  = 88;   // 13-bit values at or below take 14 bits
    localparam int TAIL_VALUE    = 90;

    // punctuation part of the alphabet, indexes 62 to 90
    localparam logic [8*29-1:0] PUNCT = {"!#$%&()*+,./:;<=>?@[]^_", 8'h60, "{|}~", 8'h22};

    typedef struct packed {
        logic       typed;   // expected characters given in c0/c1
        logic [1:0] n;
        logic       act;
        logic [7:0] byt;
        logic [7:0] c0;
        logic [7:0] c1;
    } stim_row_t;

    typedef struct packed {
        logic [6:0] ch;
        logic       fin;
        logic       msg_end;
    } char_rec_t;

    localparam stim_row_t DIRECTED [25] = '{
        '{1'b1, 2'd0, ACTION_FLUSH, 8'h00, 8'h00, 8'h00},
        '{1'b1, 2'd0, ACTION_DATA,  8'h00, 8'h00, 8'h00},
        '{1'b1, 2'd2, ACTION_DATA,  8'h00, "A",   "A"  },
        '{1'b1, 2'd1, ACTION_FLUSH, 8'hFF, "A",   8'h00},
        '{1'b1, 2'd0, ACTION_DATA,  8'hFF, 8'h00, 8'h00},
        '{1'b1, 2'd2, ACTION_DATA,  8'hFF, "B",   8'h22},
        '{1'b1, 2'd1, ACTION_FLUSH, 8'h00, "H",   8'h00},
        '{1'b1, 2'd0, ACTION_DATA,  8'h58, 8'h00, 8'h00},
        '{1'b0, 2'd0, ACTION_DATA,  8'h00, 8'h00, 8'h00},
        '{1'b0, 2'd0, ACTION_FLUSH, 8'h00, 8'h00, 8'h00},
        '{1'b1, 2'd0, ACTION_DATA,  8'h59, 8'h00, 8'h00},
        '{1'b0, 2'd0, ACTION_DATA,  8'h00, 8'h00, 8'h00},
        '{1'b0, 2'd0, ACTION_FLUSH, 8'h00, 8'h00, 8'h00},
        '{1'b1, 2'd0, ACTION_DATA,  8'h00, 8'h00, 8'h00},
        '{1'b0, 2'd0, ACTION_DATA,  8'h20, 8'h00, 8'h00},
        '{1'b0, 2'd0, ACTION_FLUSH, 8'h5A, 8'h00, 8'h00},
        '{1'b1, 2'd0, ACTION_DATA,  8'hFF, 8'h00, 8'h00},
        '{1'b1, 2'd2, ACTION_DATA,  8'hFF, "B",   8'h22},
        '{1'b0, 2'd0, ACTION_DATA,  8'h00, 8'h00, 8'h00},
        '{1'b0, 2'd0, ACTION_DATA,  8'h00, 8'h00, 8'h00},
        '{1'b0, 2'd0, ACTION_DATA,  8'h00, 8'h00, 8'h00},
        '{1'b0, 2'd0, ACTION_DATA,  8'hFF, 8'h00, 8'h00},
        '{1'b0, 2'd0, ACTION_FLUSH, 8'h00, 8'h00, 8'h00},  // seven bits left, value above 90
        '{1'b1, 2'd0, ACTION_DATA,  8'hAB, 8'h00, 8'h00},
        '{1'b0, 2'd0, ACTION_FLUSH, 8'h00, 8'h00, 8'h00}   // eight bits left
    };

    logic       aclk     = 1'b0;
    logic       aresetn  = 1'b0;
    logic       s_tvalid = 1'b0;
    logic       s_tready;
    logic [7:0] s_tdata  = 8'h00;
    logic [0:0] s_tuser  = ACTION_DATA;
    logic       m_tvalid;
    logic       m_tready = 1'b0;
    logic [7:0] m_tdata;
    logic       m_tlast;
    logic [0:0] m_tuser;

    logic [20:0] held_bits  = '0;
    logic [4:0]  held_count = '0;

    char_rec_t expected_chars [$];
    stim_row_t request_rows [$];

    int accepted_requests = 0;
    int flush_requests    = 0;
    int checked_chars     = 0;
    int error_count       = 0;
    int idle_cycles       = 0;
    int sink_hold         = 0;
    int cycle_count       = 0;
    bit send_calm         = 1'b0;
    bit sink_calm         = 1'b0;

    always #HALF_PERIOD aclk = ~aclk;

    base91_stream_encoder i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

    function automatic logic [6:0] glyph(input int digit);
        if (digit < 26) begin
            return 7'(65 + digit);
        end else if (digit < 52) begin
            return 7'(97 + digit - 26);
        end else if (digit < 62) begin
            return 7'(48 + digit - 52);
        end
        return PUNCT[8*(28 - (digit - 62)) +: 7];
    endfunction

    function automatic void push_char(input logic [6:0] code, input logic fin,
                                      input logic msg_end);
        char_rec_t rec;
        rec.ch      = code;
        rec.fin     = fin;
        rec.msg_end = msg_end;
        expected_chars.push_back(rec);
    endfunction

    // advance the bit queue by one request and queue the characters it yields
    function automatic void encode_request(input logic act, input logic [7:0] byt);
        logic [20:0] widened;
        int          value;
        widened = {13'd0, byt};
        if (act == ACTION_DATA) begin
            held_bits  = held_bits | (widened << held_count);
            held_count = held_count + 5'(OCTET_BITS);
            if (held_count > 5'(CHUNK_BITS)) begin
                if (int'(held_bits[12:0]) > NARROW_FLOOR) begin
                    value      = int'(held_bits[12:0]);
                    held_bits  = held_bits >> CHUNK_BITS;
                    held_count = held_count - 5'(CHUNK_BITS);
                end else begin
                    value      = int'(held_bits[13:0]);
                    held_bits  = held_bits >> WIDE_BITS;
                    held_count = held_count - 5'(WIDE_BITS);
                end
                push_char(glyph(value % BASE), 1'b0, 1'b0);
                push_char(glyph(value / BASE), 1'b1, 1'b0);
            end
        end else begin
            if (held_count != 0) begin
                value = int'(held_bits[12:0]);
                if (held_count > 5'(TAIL_LIMIT) || value > TAIL_VALUE) begin
                    push_char(glyph(value % BASE), 1'b0, 1'b0);
                    push_char(glyph(value / BASE), 1'b1, 1'b1);
                end else begin
                    push_char(glyph(value % BASE), 1'b1, 1'b1);
                end
            end
            held_bits  = '0;
            held_count = '0;
        end
    endfunction

    task automatic flag_error(input string msg);
        error_count++;
        if (error_count <= REPORT_LIMIT) begin
            $display("%s", msg);
        end
    endtask

    // check results, then predict for the request taken at this edge
    always @(posedge aclk) begin
        stim_row_t row;
        char_rec_t want;
        int        base;
        if (aresetn) begin
            if (m_tvalid && m_tready) begin
                checked_chars++;
                if (expected_chars.size() == 0) begin
                    flag_error($sformatf("unexpected char: data=%h last=%b end=%b",
                                         m_tdata, m_tlast, m_tuser));
                end else begin
                    want = expected_chars.pop_front();
                    if ({m_tdata, m_tlast, m_tuser} != {1'b0, want.ch, want.fin, want.msg_end})
                    begin
                        flag_error($sformatf(
                            "char %0d: expected data=%h last=%b end=%b, got data=%h last=%b end=%b",
                            checked_chars, {1'b0, want.ch}, want.fin, want.msg_end,
                            m_tdata, m_tlast, m_tuser));
                    end
                end
            end
            if (s_tvalid && s_tready) begin
                row  = request_rows.pop_front();
                base = expected_chars.size();
                encode_request(s_tuser[0], s_tdata);
                if (row.typed) begin
                    while (expected_chars.size() > base) begin
                        void'(expected_chars.pop_back());
                    end
                    if (row.n == 2'd1) begin
                        push_char(row.c0[6:0], 1'b1, row.act == ACTION_FLUSH);
                    end else if (row.n == 2'd2) begin
                        push_char(row.c0[6:0], 1'b0, 1'b0);
                        push_char(row.c1[6:0], 1'b1, row.act == ACTION_FLUSH);
                    end
                end
                if (s_tuser[0] == ACTION_FLUSH) begin
                    flush_requests++;
                end
                accepted_requests++;
            end
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
                idle_cycles = 0;
            end else begin
                idle_cycles++;
            end
        end
    end

    // result side: mostly ready, short and long stalls, calm stretches
    always @(negedge aclk) begin
        int roll;
        cycle_count++;
        if (cycle_count % 128 == 0) begin
            sink_calm = ($urandom_range(0, 3) == 0);
        end
        roll = $urandom_range(0, 99);
        if (sink_hold > 0) begin
            sink_hold--;
            m_tready <= 1'b0;
        end else if (sink_calm || roll < 70) begin
            m_tready <= 1'b1;
        end else if (roll < 94) begin
            sink_hold = $urandom_range(0, 2);
            m_tready <= 1'b0;
        end else begin
            sink_hold = $urandom_range(10, 40);
            m_tready <= 1'b0;
        end
    end

    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (send_calm || roll < 60) begin
            return 0;
        end else if (roll < 92) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 30);
    endfunction

    function automatic stim_row_t random_row();
        stim_row_t row;
        int        roll;
        row  = '0;
        roll = $urandom_range(0, 99);
        row.act = (roll < 8) ? ACTION_FLUSH : ACTION_DATA;
        roll = $urandom_range(0, 99);
        if (roll < 25) begin
            row.byt = 8'($urandom_range(0, 10));
        end else if (roll < 30) begin
            row.byt = 8'h00;
        end else if (roll < 35) begin
            row.byt = 8'hFF;
        end else begin
            row.byt = 8'($urandom_range(0, 255));
        end
        return row;
    endfunction

    // called at a falling edge; returns at the falling edge after the request is taken
    task automatic send_request(input stim_row_t row);
        int gap;
        int target;
        gap = pick_gap();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        request_rows.push_back(row);
        target = accepted_requests + 1;
        s_tuser  <= row.act;
        s_tdata  <= row.byt;
        s_tvalid <= 1'b1;
        do @(negedge aclk); while (accepted_requests < target);
    endtask

    initial begin
        stim_row_t flush_row;
        repeat (RESET_CYCLES) @(negedge aclk);
        aresetn <= 1'b1;
        for (int k = 0; k < 25; k++) begin
            send_request(DIRECTED[k]);
        end
        for (int k = 0; k < RANDOM_ITEMS; k++) begin
            if (k % 40 == 0) begin
                send_calm = ($urandom_range(0, 3) == 0);
            end
            if (k == RANDOM_ITEMS / 2) begin
                // hold the sender until the result side has caught up
                s_tvalid <= 1'b0;
                do @(negedge aclk); while (expected_chars.size() != 0);
            end
            send_request(random_row());
        end
        flush_row     = '0;
        flush_row.act = ACTION_FLUSH;
        send_request(flush_row);
        s_tvalid <= 1'b0;
        while (expected_chars.size() != 0) @(negedge aclk);
        repeat (DRAIN_CYCLES) @(negedge aclk);
        $display("covered %0d requests including %0d flushes, %0d characters compared",
                 accepted_requests, flush_requests, checked_chars);
        $display("errors: %0d, characters still awaited: %0d",
                 error_count, expected_chars.size());
        if (error_count == 0 && expected_chars.size() == 0) begin
            $display("base91_stream_encoder: match");
        end else begin
            $display("base91_stream_encoder: mismatch");
        end
        $finish;
    end

    initial begin
        wait (aresetn);
        while (idle_cycles < STALL_LIMIT) @(negedge aclk);
        $display("timeout: no transfer for %0d cycles", STALL_LIMIT);
        $display("base91_stream_encoder: mismatch");
        $finish;
    end

endmodule
